[src/bpru_pkg.sv]
// shared types and constants of the bmp pixel row unpacker
package bpru_pkg;

  localparam int MaxWidth   = 4096;
  localparam int MaxHeight  = 4096;
  localparam int QueueDepth = 4;

  localparam logic [1:0] CfgDepthMode   = 2'd0;
  localparam logic [1:0] CfgImageWidth  = 2'd1;
  localparam logic [1:0] CfgImageHeight = 2'd2;

  localparam logic [1:0] Mode1Bit  = 2'd0;
  localparam logic [1:0] Mode4Bit  = 2'd1;
  localparam logic [1:0] Mode8Bit  = 2'd2;
  localparam logic [1:0] Mode24Bit = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_blue;
    logic [7:0] palette_green;
    logic [7:0] palette_red;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_in_item;
    logic        last_of_image;
  } out_pixel_t;

  // one unit of work for the back end: a palette write or a run of pixels
  typedef struct packed {
    logic        is_write;
    logic [1:0]  mode;
    logic [3:0]  count;
    logic [7:0]  data;
    logic [23:0] color;      // {red, green, blue}
    logic [11:0] start_col;
    logic [11:0] out_row;
    logic        row_last;
  } job_t;

endpackage

[src/bmp_pixel_row_unpacker_top.sv]
// top level of the bmp pixel row unpacker
// Input channel: in_valid_i / in_stall_o carry one beat per byte of pixel data
// (operation 1) or one palette write (operation 0). Output channel:
// out_valid_o / out_stall_i carry one pixel per beat with row, column, color
// and the last-in-item and last-of-image flags.
// Configuration (depth mode, width, height) is written through cfg_we_i,
// cfg_index_i and cfg_data_i, by the user only while the block is idle; the
// block does not enforce this. Each write restarts the image position and
// keeps the palette. With an empty queue a pixel byte's job passes through the
// job queue and then the back-end output register before its first pixel is
// valid. While out_stall_i is low the back end gives one pixel per cycle; a byte
// yields up to eight pixels in 1-bit mode, a 24-bit blue or green byte none. The
// front end takes a beat per cycle until the four-entry job queue is full.
// Reset clears position, configuration (24-bit, 1x1) and the queue; the
// palette holds garbage until written. While out_stall_i is high the current
// pixel holds and the queue fills, then in_stall_o rises.
module bmp_pixel_row_unpacker_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bpru_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bpru_pkg::out_pixel_t out_pixel_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [12:0]          cfg_data_i
);

  logic           push, full, pop, q_valid;
  bpru_pkg::job_t push_job, head;
  logic [11:0]    wlast;

  bpru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job),
    .wlast_o    (wlast)
  );

  bpru_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (head)
  );

  bpru_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .wlast_i    (wlast),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_pixel_o(out_pixel_o)
  );

endmodule

[src/bpru_front.sv]
// front end: configuration, row and column tracking, job building
module bpru_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpru_pkg::in_item_t in_item_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bpru_pkg::job_t    job_o,
  output logic [11:0]       wlast_o
);

  logic [1:0]  mode_q, mode_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic [13:0] byte_q, byte_d;
  logic [12:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [7:0]  held_blue_q, held_blue_d;
  logic [7:0]  held_green_q, held_green_d;
  logic [1:0]  phase_q, phase_d;

  logic [12:0] w, h;
  logic [17:0] row_bits;
  logic [17:0] row_bits_rnd;
  logic [13:0] row_bytes;
  logic [12:0] remain;
  logic [3:0]  per;
  logic [3:0]  n;
  logic        accept;
  logic [13:0] byte_inc;

  always_comb begin
    w = width_q;
    if (width_q == 13'd0) begin
      w = 13'd1;
    end else if (width_q > 13'(bpru_pkg::MaxWidth)) begin
      w = 13'(bpru_pkg::MaxWidth);
    end
    h = height_q;
    if (height_q == 13'd0) begin
      h = 13'd1;
    end else if (height_q > 13'(bpru_pkg::MaxHeight)) begin
      h = 13'(bpru_pkg::MaxHeight);
    end
  end

  // row length in bytes, rounded up to whole 32-bit words
  always_comb begin
    case (mode_q)
      bpru_pkg::Mode1Bit: row_bits = 18'(w);
      bpru_pkg::Mode4Bit: row_bits = 18'(w) << 2;
      bpru_pkg::Mode8Bit: row_bits = 18'(w) << 3;
      default:            row_bits = (18'(w) << 4) + (18'(w) << 3);
    endcase
    row_bits_rnd = row_bits + 18'd31;
    row_bytes    = {row_bits_rnd[16:5], 2'b00};
  end

  always_comb begin
    case (mode_q)
      bpru_pkg::Mode1Bit: per = 4'd8;
      bpru_pkg::Mode4Bit: per = 4'd2;
      default:            per = 4'd1;
    endcase
    remain = w - col_q;
    if (col_q >= w) begin
      n = 4'd0;
    end else if (remain < 13'(per)) begin
      n = remain[3:0];
    end else begin
      n = per;
    end
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign wlast_o    = 12'(w - 13'd1);
  assign byte_inc   = byte_q + 14'd1;

  always_comb begin
    mode_d       = mode_q;
    width_d      = width_q;
    height_d     = height_q;
    byte_d       = byte_q;
    col_d        = col_q;
    row_d        = row_q;
    held_blue_d  = held_blue_q;
    held_green_d = held_green_q;
    phase_d      = phase_q;
    push_o       = 1'b0;

    job_o.is_write  = 1'b0;
    job_o.mode      = mode_q;
    job_o.count     = n;
    job_o.data      = in_item_i.data_byte;
    job_o.color     = {in_item_i.palette_red, in_item_i.palette_green,
                       in_item_i.palette_blue};
    job_o.start_col = col_q[11:0];
    job_o.out_row   = 12'(h - 13'd1 - row_q);
    job_o.row_last  = (row_q == h - 13'd1);

    if (cfg_we_i && cfg_index_i <= bpru_pkg::CfgImageHeight) begin
      unique case (cfg_index_i)
        bpru_pkg::CfgDepthMode:  mode_d   = cfg_data_i[1:0];
        bpru_pkg::CfgImageWidth: width_d  = cfg_data_i;
        default:                 height_d = cfg_data_i;
      endcase
      byte_d       = '0;
      col_d        = '0;
      row_d        = '0;
      held_blue_d  = '0;
      held_green_d = '0;
      phase_d      = '0;
    end else if (accept) begin
      if (!in_item_i.operation) begin
        job_o.is_write = 1'b1;
        job_o.data     = in_item_i.palette_index;
        push_o         = 1'b1;
      end else if (row_q < h) begin
        if (mode_q == bpru_pkg::Mode24Bit) begin
          job_o.count = 4'd1;
          job_o.color = {in_item_i.data_byte, held_green_q, held_blue_q};
          if (col_q < w) begin
            unique case (phase_q)
              2'd0: begin
                held_blue_d = in_item_i.data_byte;
                phase_d     = 2'd1;
              end
              2'd1: begin
                held_green_d = in_item_i.data_byte;
                phase_d      = 2'd2;
              end
              default: begin
                push_o  = 1'b1;
                col_d   = col_q + 13'd1;
                phase_d = 2'd0;
              end
            endcase
          end
        end else begin
          push_o = (n != 4'd0);
          col_d  = col_q + 13'(n);
        end
        byte_d = byte_inc;
        if (byte_inc >= row_bytes) begin
          byte_d  = '0;
          col_d   = '0;
          phase_d = '0;
          row_d   = row_q + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= bpru_pkg::Mode24Bit;
      width_q      <= 13'd1;
      height_q     <= 13'd1;
      byte_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      held_blue_q  <= '0;
      held_green_q <= '0;
      phase_q      <= '0;
    end else begin
      mode_q       <= mode_d;
      width_q      <= width_d;
      height_q     <= height_d;
      byte_q       <= byte_d;
      col_q        <= col_d;
      row_q        <= row_d;
      held_blue_q  <= held_blue_d;
      held_green_q <= held_green_d;
      phase_q      <= phase_d;
    end
  end

endmodule

[src/bpru_fifo.sv]
// short job queue between front and back end
module bpru_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpru_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bpru_pkg::job_t head_o
);

  localparam int PtrW = $clog2(bpru_pkg::QueueDepth);

  bpru_pkg::job_t entries_q [bpru_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(bpru_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/bpru_back.sv]
// back end: palette memory and a sequencer giving one pixel per cycle unless out_stall_i holds it
module bpru_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  bpru_pkg::job_t       head_i,
  output logic                 pop_o,
  input  logic [11:0]          wlast_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bpru_pkg::out_pixel_t out_pixel_o
);

  logic [23:0] pal_mem [256];
  logic [23:0] rdata_q;

  logic [2:0]  k_q, k_d;
  logic        b_valid_q, b_valid_d;
  logic [11:0] row_q, col_q;
  logic        last_item_q, last_image_q, direct_q;
  logic [23:0] direct_color_q;

  logic        b_ready;
  logic        pal_we;
  logic        issue;
  logic        last_px;
  logic [7:0]  idx;
  logic [11:0] col;

  assign b_ready = !b_valid_q || !out_stall_i;
  assign pal_we  = q_valid_i && head_i.is_write;
  assign issue   = q_valid_i && !head_i.is_write && b_ready;
  assign last_px = ({1'b0, k_q} == head_i.count - 4'd1);
  assign pop_o   = pal_we || (issue && last_px);
  assign col     = head_i.start_col + 12'(k_q);

  // palette index of the current pixel, most significant first
  always_comb begin
    case (head_i.mode)
      bpru_pkg::Mode1Bit: idx = {7'd0, head_i.data[3'd7 - k_q]};
      bpru_pkg::Mode4Bit: idx = k_q[0] ? {4'd0, head_i.data[3:0]}
                                       : {4'd0, head_i.data[7:4]};
      default:            idx = head_i.data;
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (issue) begin
      k_d = last_px ? 3'd0 : k_q + 3'd1;
    end
    b_valid_d = b_valid_q;
    if (issue) begin
      b_valid_d = 1'b1;
    end else if (b_ready) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[head_i.data] <= head_i.color;
    end
    if (issue) begin
      rdata_q <= pal_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      row_q          <= head_i.out_row;
      col_q          <= col;
      last_item_q    <= last_px;
      last_image_q   <= head_i.row_last && (col == wlast_i);
      direct_q       <= (head_i.mode == bpru_pkg::Mode24Bit);
      direct_color_q <= head_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      b_valid_q <= 1'b0;
    end else begin
      k_q       <= k_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_comb begin
    logic [23:0] c;
    c = direct_q ? direct_color_q : rdata_q;
    out_pixel_o.pixel_row     = row_q;
    out_pixel_o.pixel_column  = col_q;
    out_pixel_o.red           = c[23:16];
    out_pixel_o.green         = c[15:8];
    out_pixel_o.blue          = c[7:0];
    out_pixel_o.last_in_item  = last_item_q;
    out_pixel_o.last_of_image = last_image_q;
  end

  assign out_valid_o = b_valid_q;

endmodule
